FILE: rtl/tlg_pkg.sv
// Shared widths, constants and status type for the tetrahedron gradient block.
`default_nettype none
package tlg_pkg;
    // exact intermediate width (cross products, triple product, numerators)
    localparam int unsigned WIDE_W  = 128;
    // coordinate and value width
    localparam int unsigned WORD_W  = 32;
    // width of a coordinate or value difference
    localparam int unsigned DIFF_W  = WORD_W + 1;
    // corner slot that triggers the computation
    localparam logic [1:0]  SLOT_H  = 2'd3;

    // status of a shared multi-cycle unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;
endpackage
`default_nettype wire

FILE: rtl/tlg_mul.sv
// Shared shift-add multiplier: signed wide operand times signed difference.
`default_nettype none
module tlg_mul (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic signed [tlg_pkg::WIDE_W-1:0]    i_a,
    input  wire logic signed [tlg_pkg::DIFF_W-1:0]    i_b,
    output logic signed [tlg_pkg::WIDE_W-1:0]         o_prod,
    output tlg_pkg::t_unit_sts                        o_sts
);
    localparam int unsigned CNT_W = $clog2(tlg_pkg::DIFF_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(tlg_pkg::DIFF_W - 1);

    logic [tlg_pkg::WIDE_W-1:0] r_mcand;
    logic [tlg_pkg::DIFF_W-1:0] r_mplier;
    logic [tlg_pkg::WIDE_W-1:0] r_prod;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;

    // control: one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: the sign bit of the multiplier carries negative weight
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= i_a;
            r_mplier <= i_b;
            r_prod   <= '0;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                if (r_cnt == LAST) r_prod <= r_prod - r_mcand;
                else               r_prod <= r_prod + r_mcand;
            end
            r_mcand  <= {r_mcand[tlg_pkg::WIDE_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[tlg_pkg::DIFF_W-1:1]};
        end
    end

    assign o_prod      = r_prod;
    assign o_sts.busy  = r_busy;
    assign o_sts.done  = r_done;
endmodule
`default_nettype wire

FILE: rtl/tlg_div.sv
// Shared restoring divider, one quotient bit per cycle, unsigned wide operands.
`default_nettype none
module tlg_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [tlg_pkg::WIDE_W-1:0]    i_num,
    input  wire logic [tlg_pkg::WIDE_W-1:0]    i_den,
    output logic [tlg_pkg::WIDE_W-1:0]         o_quo,
    output tlg_pkg::t_unit_sts                 o_sts
);
    localparam int unsigned CNT_W = $clog2(tlg_pkg::WIDE_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(tlg_pkg::WIDE_W - 1);

    logic [tlg_pkg::WIDE_W-1:0] r_rem;
    logic [tlg_pkg::WIDE_W-1:0] r_quo;
    logic [tlg_pkg::WIDE_W-1:0] r_den;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [tlg_pkg::WIDE_W:0]   trial;

    // shift in the next numerator bit and try the subtraction
    always_comb begin
        trial = {r_rem, r_quo[tlg_pkg::WIDE_W-1]} - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!trial[tlg_pkg::WIDE_W]) begin
                r_rem <= trial[tlg_pkg::WIDE_W-1:0];
                r_quo <= {r_quo[tlg_pkg::WIDE_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[tlg_pkg::WIDE_W-2:0], r_quo[tlg_pkg::WIDE_W-1]};
                r_quo <= {r_quo[tlg_pkg::WIDE_W-2:0], 1'b0};
            end
        end
    end

    assign o_quo      = r_quo;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
endmodule
`default_nettype wire

FILE: rtl/tetrahedron_linear_gradient.sv
// Top level: corner store, sequencer and result register of the gradient block.
//
// Use: stream the four corners of a tetrahedron on the slave channel, one item
// each; tuser carries the corner slot, tdata the x, y, z coordinates and the
// scalar value. Slots 0..2 are only stored. A slot 3 item is stored and starts
// the gradient computation; the block then holds tready low. The computation
// runs 30 products on one shift-add multiplier (each with issue, multiplier bit
// loop and accumulate) and three divisions on one restoring divider (each with
// setup and quotient bit loop). When the tetrahedron is degenerate, only the
// products up to the triple product run and no division follows.
// The result (gradient x, y, z and the degenerate and saturated flags) sits in
// an output register on the master channel until taken. While it waits, new
// corners are accepted; a further slot 3 computation stalls only in its final
// state until the register is free.
// Reset clears the sequencer and the output valid; the corner store is not
// cleared and must be loaded before the first slot 3 item.
`default_nettype none
module tetrahedron_linear_gradient #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // [31:0] vertex_x, [63:32] vertex_y, [95:64] vertex_z, [127:96] vertex_value
    input  wire logic [127:0] i_s_axis_tdata,
    // [1:0] vertex_slot
    input  wire logic [1:0]   i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // [31:0] grad_x, [63:32] grad_y, [95:64] grad_z
    output logic [95:0]       o_m_axis_tdata,
    // [0] degenerate, [1] saturated
    output logic [1:0]        o_m_axis_tuser
);
    localparam int unsigned W  = tlg_pkg::WIDE_W;
    localparam int unsigned WW = tlg_pkg::WORD_W;
    localparam int unsigned DW = tlg_pkg::DIFF_W;
    localparam logic [4:0] OP_D_LAST = 5'd20;
    localparam logic [4:0] OP_N_FIRST = 5'd21;
    localparam logic [4:0] OP_LAST = 5'd29;
    localparam logic [3:0] RES_D = 4'd9;
    localparam logic [3:0] RES_N = 4'd10;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_PREP  = 9'b000000010,
        ST_ISSUE = 9'b000000100,
        ST_MUL   = 9'b000001000,
        ST_ACC   = 9'b000010000,
        ST_CHECK = 9'b000100000,
        ST_DSET  = 9'b001000000,
        ST_DIV   = 9'b010000000,
        ST_FIN   = 9'b100000000
    } t_state;

    typedef struct packed {
        logic       a_res;   // A from result store, else from u vectors
        logic [3:0] a_sel;
        logic [3:0] b_sel;
        logic       sub;
        logic       first;
        logic       last;
        logic [3:0] dest;
    } t_op;

    function automatic t_op mk(input logic a_res, input logic [3:0] a, input logic [3:0] b,
                               input logic sub, input logic first, input logic last,
                               input logic [3:0] dest);
        t_op o;
        o.a_res = a_res; o.a_sel = a; o.b_sel = b; o.sub = sub;
        o.first = first; o.last = last; o.dest = dest;
        return o;
    endfunction

    // product schedule: three cross products, triple product, three numerators
    function automatic t_op op_table(input logic [4:0] o);
        t_op r;
        case (o)
            5'd0:  r = mk(1'b0, 4'd1, 4'd2, 1'b0, 1'b1, 1'b0, 4'd0);
            5'd1:  r = mk(1'b0, 4'd2, 4'd1, 1'b1, 1'b0, 1'b1, 4'd0);
            5'd2:  r = mk(1'b0, 4'd2, 4'd0, 1'b0, 1'b1, 1'b0, 4'd1);
            5'd3:  r = mk(1'b0, 4'd0, 4'd2, 1'b1, 1'b0, 1'b1, 4'd1);
            5'd4:  r = mk(1'b0, 4'd0, 4'd1, 1'b0, 1'b1, 1'b0, 4'd2);
            5'd5:  r = mk(1'b0, 4'd1, 4'd0, 1'b1, 1'b0, 1'b1, 4'd2);
            5'd6:  r = mk(1'b0, 4'd4, 4'd5, 1'b0, 1'b1, 1'b0, 4'd3);
            5'd7:  r = mk(1'b0, 4'd5, 4'd4, 1'b1, 1'b0, 1'b1, 4'd3);
            5'd8:  r = mk(1'b0, 4'd5, 4'd3, 1'b0, 1'b1, 1'b0, 4'd4);
            5'd9:  r = mk(1'b0, 4'd3, 4'd5, 1'b1, 1'b0, 1'b1, 4'd4);
            5'd10: r = mk(1'b0, 4'd3, 4'd4, 1'b0, 1'b1, 1'b0, 4'd5);
            5'd11: r = mk(1'b0, 4'd4, 4'd3, 1'b1, 1'b0, 1'b1, 4'd5);
            5'd12: r = mk(1'b0, 4'd7, 4'd8, 1'b0, 1'b1, 1'b0, 4'd6);
            5'd13: r = mk(1'b0, 4'd8, 4'd7, 1'b1, 1'b0, 1'b1, 4'd6);
            5'd14: r = mk(1'b0, 4'd8, 4'd6, 1'b0, 1'b1, 1'b0, 4'd7);
            5'd15: r = mk(1'b0, 4'd6, 4'd8, 1'b1, 1'b0, 1'b1, 4'd7);
            5'd16: r = mk(1'b0, 4'd6, 4'd7, 1'b0, 1'b1, 1'b0, 4'd8);
            5'd17: r = mk(1'b0, 4'd7, 4'd6, 1'b1, 1'b0, 1'b1, 4'd8);
            5'd18: r = mk(1'b1, 4'd0, 4'd6, 1'b0, 1'b1, 1'b0, 4'd9);
            5'd19: r = mk(1'b1, 4'd1, 4'd7, 1'b0, 1'b0, 1'b0, 4'd9);
            5'd20: r = mk(1'b1, 4'd2, 4'd8, 1'b0, 1'b0, 1'b1, 4'd9);
            5'd21: r = mk(1'b1, 4'd0, 4'd9,  1'b0, 1'b1, 1'b0, 4'd10);
            5'd22: r = mk(1'b1, 4'd3, 4'd10, 1'b0, 1'b0, 1'b0, 4'd10);
            5'd23: r = mk(1'b1, 4'd6, 4'd11, 1'b0, 1'b0, 1'b1, 4'd10);
            5'd24: r = mk(1'b1, 4'd1, 4'd9,  1'b0, 1'b1, 1'b0, 4'd11);
            5'd25: r = mk(1'b1, 4'd4, 4'd10, 1'b0, 1'b0, 1'b0, 4'd11);
            5'd26: r = mk(1'b1, 4'd7, 4'd11, 1'b0, 1'b0, 1'b1, 4'd11);
            5'd27: r = mk(1'b1, 4'd2, 4'd9,  1'b0, 1'b1, 1'b0, 4'd12);
            5'd28: r = mk(1'b1, 4'd5, 4'd10, 1'b0, 1'b0, 1'b0, 4'd12);
            5'd29: r = mk(1'b1, 4'd8, 4'd11, 1'b0, 1'b0, 1'b1, 4'd12);
            default: r = mk(1'b0, 4'd0, 4'd0, 1'b0, 1'b1, 1'b1, 4'd0);
        endcase
        return r;
    endfunction

    function automatic logic signed [DW-1:0] diff(input logic [WW-1:0] a,
                                                  input logic [WW-1:0] b);
        return $signed({a[WW-1], a}) - $signed({b[WW-1], b});
    endfunction

    // corner store, written by slot
    logic [WW-1:0] r_cx [4];
    logic [WW-1:0] r_cy [4];
    logic [WW-1:0] r_cz [4];
    logic [WW-1:0] r_cv [4];

    // difference vectors: u side (vki, vhi, vik), v side (vkh, vhj, vij, dv)
    logic signed [DW-1:0] r_ua [9];
    logic signed [DW-1:0] r_vb [12];
    // results: C1, C2, C3 components, D, three numerators
    logic signed [W-1:0]  r_res [13];

    t_state               r_state;
    logic [4:0]           r_op;
    logic [1:0]           r_comp;
    logic signed [W-1:0]  r_acc;
    logic                 r_neg;
    logic [WW-1:0]        r_g [3];
    logic                 r_sat;
    logic                 r_deg;
    logic                 r_out_valid;
    logic [95:0]          r_out_data;
    logic [1:0]           r_out_user;

    t_op                  op;
    logic [3:0]           rd_sel;
    logic signed [W-1:0]  rd_res;
    logic signed [W-1:0]  a_opnd;
    logic signed [W-1:0]  acc_in;
    logic signed [W-1:0]  acc_new;
    logic signed [W-1:0]  d_val;
    logic [W-1:0]         n_abs;
    logic [W-1:0]         d_abs;
    logic [W-1:0]         num_sh;
    logic                 mul_start;
    logic                 div_start;
    logic signed [W-1:0]  mul_prod;
    logic [W-1:0]         div_quo;
    tlg_pkg::t_unit_sts   mul_sts;
    tlg_pkg::t_unit_sts   div_sts;
    logic                 s_fire;
    logic                 out_free;
    logic [WW-1:0]        lim;
    logic                 clip;
    logic [WW-1:0]        mag;

    assign s_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    // operand fetch: one selected read port on the result store, plus a fixed read of D
    always_comb begin
        op       = op_table(r_op);
        rd_sel   = (r_state == ST_DSET) ? RES_N + {2'b00, r_comp} : op.a_sel;
        rd_res   = r_res[rd_sel];
        a_opnd   = op.a_res ? rd_res : {{(W-DW){r_ua[op.a_sel][DW-1]}}, r_ua[op.a_sel]};
        acc_in   = op.first ? '0 : r_acc;
        acc_new  = op.sub ? acc_in - mul_prod : acc_in + mul_prod;
        d_val    = r_res[RES_D];
        n_abs    = rd_res[W-1] ? W'(-rd_res) : W'(rd_res);
        d_abs    = d_val[W-1] ? W'(-d_val) : W'(d_val);
        num_sh   = n_abs << FRAC_BITS;
        mul_start = (r_state == ST_ISSUE);
        div_start = (r_state == ST_DSET);
    end

    // quotient saturation to 32 bits
    always_comb begin
        lim  = r_neg ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
        clip = (div_quo[W-1:WW] != '0) || (div_quo[WW-1:0] > lim);
        mag  = clip ? lim : div_quo[WW-1:0];
    end

    tlg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (a_opnd),
        .i_b     (r_vb[op.b_sel]),
        .o_prod  (mul_prod),
        .o_sts   (mul_sts)
    );

    // operands go straight in: the divider latches them on its start cycle
    tlg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_sh),
        .i_den   (d_abs),
        .o_quo   (div_quo),
        .o_sts   (div_sts)
    );

    // corner store
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_cx[i_s_axis_tuser] <= i_s_axis_tdata[31:0];
            r_cy[i_s_axis_tuser] <= i_s_axis_tdata[63:32];
            r_cz[i_s_axis_tuser] <= i_s_axis_tdata[95:64];
            r_cv[i_s_axis_tuser] <= i_s_axis_tdata[127:96];
        end
    end

    // difference vectors, formed once per tetrahedron
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PREP) begin
            r_ua[0] <= diff(r_cx[0], r_cx[2]);
            r_ua[1] <= diff(r_cy[0], r_cy[2]);
            r_ua[2] <= diff(r_cz[0], r_cz[2]);
            r_ua[3] <= diff(r_cx[0], r_cx[3]);
            r_ua[4] <= diff(r_cy[0], r_cy[3]);
            r_ua[5] <= diff(r_cz[0], r_cz[3]);
            r_ua[6] <= diff(r_cx[2], r_cx[0]);
            r_ua[7] <= diff(r_cy[2], r_cy[0]);
            r_ua[8] <= diff(r_cz[2], r_cz[0]);
            r_vb[0] <= diff(r_cx[3], r_cx[2]);
            r_vb[1] <= diff(r_cy[3], r_cy[2]);
            r_vb[2] <= diff(r_cz[3], r_cz[2]);
            r_vb[3] <= diff(r_cx[1], r_cx[3]);
            r_vb[4] <= diff(r_cy[1], r_cy[3]);
            r_vb[5] <= diff(r_cz[1], r_cz[3]);
            r_vb[6] <= diff(r_cx[1], r_cx[0]);
            r_vb[7] <= diff(r_cy[1], r_cy[0]);
            r_vb[8] <= diff(r_cz[1], r_cz[0]);
            r_vb[9]  <= diff(r_cv[1], r_cv[0]);
            r_vb[10] <= diff(r_cv[2], r_cv[0]);
            r_vb[11] <= diff(r_cv[3], r_cv[0]);
        end
    end

    // accumulator and result store
    always_ff @(posedge i_clk) begin
        if (r_state == ST_ACC) begin
            r_acc <= acc_new;
            if (op.last) r_res[op.dest] <= acc_new;
        end
    end

    // division sign, degenerate and saturated flags and gradient components
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DSET) begin
            r_neg <= rd_res[W-1] ^ d_val[W-1];
        end
        if (r_state == ST_CHECK) begin
            r_g[0] <= '0;
            r_g[1] <= '0;
            r_g[2] <= '0;
            r_deg  <= (d_val == '0);
            r_sat  <= 1'b0;
        end else if (r_state == ST_DIV && div_sts.done) begin
            r_g[r_comp] <= r_neg ? WW'(-mag) : mag;
            r_sat       <= r_sat | clip;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= '0;
            r_comp  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (s_fire && i_s_axis_tuser == tlg_pkg::SLOT_H) r_state <= ST_PREP;
                end
                ST_PREP: begin
                    r_op    <= '0;
                    r_state <= ST_ISSUE;
                end
                ST_ISSUE: r_state <= ST_MUL;
                ST_MUL: begin
                    if (mul_sts.done) r_state <= ST_ACC;
                end
                ST_ACC: begin
                    if (r_op == OP_D_LAST) begin
                        r_state <= ST_CHECK;
                    end else if (r_op == OP_LAST) begin
                        r_comp  <= '0;
                        r_state <= ST_DSET;
                    end else begin
                        r_op    <= r_op + 1'b1;
                        r_state <= ST_ISSUE;
                    end
                end
                ST_CHECK: begin
                    if (d_val == '0) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_op    <= OP_N_FIRST;
                        r_state <= ST_ISSUE;
                    end
                end
                ST_DSET: r_state <= ST_DIV;
                ST_DIV: begin
                    if (div_sts.done) begin
                        if (r_comp == 2'd2) begin
                            r_state <= ST_FIN;
                        end else begin
                            r_comp  <= r_comp + 1'b1;
                            r_state <= ST_DSET;
                        end
                    end
                end
                ST_FIN: begin
                    if (out_free) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && out_free) begin
            r_out_data <= {r_g[2], r_g[1], r_g[0]};
            r_out_user <= {r_sat, r_deg};
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
endmodule
`default_nettype wire

FILE: rtl/tlg_checker.sv
// Port-level checker for the tetrahedron gradient block, with its bind.
`default_nettype none
module tlg_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_axis_tvalid,
    input wire logic         o_s_axis_tready,
    input wire logic [1:0]   i_s_axis_tuser,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [95:0]  o_m_axis_tdata,
    input wire logic [1:0]   o_m_axis_tuser
);
    // a slot 3 item starts a computation: no item taken next cycle
    a_busy_after_trigger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == tlg_pkg::SLOT_H)
            |=> !o_s_axis_tready)
        else $error("ready high right after a slot 3 item");

    // storing a corner alone keeps the block ready
    a_ready_after_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser != tlg_pkg::SLOT_H)
            |=> o_s_axis_tready)
        else $error("ready dropped after a corner store");

    // degenerate result carries a zero gradient and no clipping
    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0 && !o_m_axis_tuser[1]))
        else $error("degenerate result with nonzero gradient or saturation");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result changed while stalled");
endmodule

bind tetrahedron_linear_gradient tlg_checker u_tlg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
`default_nettype wire
